/* rtl/sample_fifo_history_window_defines.svh */
// Assertion macros for the sample history window block.
`ifndef SAMPLE_FIFO_HISTORY_WINDOW_DEFINES_SVH
`define SAMPLE_FIFO_HISTORY_WINDOW_DEFINES_SVH

`ifndef SYNTH
// Checked property, masked while reset is high.
`define SFHW_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked property that must also hold during reset.
`define SFHW_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SFHW_CHECK(label, prop, msg)
`define SFHW_CHECK_ALWAYS(label, prop, msg)
`endif

`endif

/* rtl/sfhw_pkg.sv */
package sfhw_pkg;

   localparam int WORD_W     = 32;
   localparam int FIFO_DEPTH = 1024;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
   localparam int HIST_DEPTH = 64;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int LEN_W      = 7;

   localparam logic [LEN_W-1:0] HIST_LEN_RESET = 7'd64;

   localparam logic CMD_PUSH     = 1'b0;
   localparam logic CMD_SNAPSHOT = 1'b1;

   // One classified request waiting for the back end.
   typedef struct packed {
      logic              is_snap;
      logic [WORD_W-1:0] word;
      logic              batch_end;
   } sfhw_item_type;

   // Status of the back end, watched by the top level.
   typedef struct packed {
      logic               busy;
      logic               emitting;
      logic [FIFO_CW-1:0] fifo_count;
   } sfhw_status_type;

endpackage

/* rtl/sfhw_front.sv */
module sfhw_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [sfhw_pkg::WORD_W-1:0]       req_sample_word,
   input  logic                              req_batch_end,
   output logic                              item_valid,
   output sfhw_pkg::sfhw_item_type           item,
   input  logic                              item_pop
);

   sfhw_pkg::sfhw_item_type ent_ff [2];
   logic                    rd_ptr_ff, rd_ptr_in;
   logic                    wr_ptr_ff, wr_ptr_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic                    push;
   sfhw_pkg::sfhw_item_type new_item;

   assign req_stall  = (cnt_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = ent_ff[rd_ptr_ff];

   always_comb begin
      new_item.is_snap   = (req_cmd == sfhw_pkg::CMD_SNAPSHOT);
      new_item.word      = req_sample_word;
      new_item.batch_end = req_batch_end;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* rtl/sfhw_back.sv */
module sfhw_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [sfhw_pkg::LEN_W-1:0]        csr_write_data,
   input  logic                              item_valid,
   input  sfhw_pkg::sfhw_item_type           item,
   output logic                              item_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sfhw_pkg::WORD_W-1:0]       rsp_history_sample,
   output logic                              rsp_last_sample,
   output sfhw_pkg::sfhw_status_type         status
);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_DRAIN     = 5'b00010,
      ST_EMIT_RD   = 5'b00100,
      ST_EMIT_LD   = 5'b01000,
      ST_EMIT_HOLD = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   logic [sfhw_pkg::LEN_W-1:0]      hist_len_ff, hist_len_in;
   logic [sfhw_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [sfhw_pkg::LEN_W-1:0]      eff_len;
   logic [sfhw_pkg::FIFO_AW-1:0]    fifo_head_ff, fifo_head_in;
   logic [sfhw_pkg::FIFO_AW-1:0]    fifo_tail_ff, fifo_tail_in;
   logic [sfhw_pkg::FIFO_CW-1:0]    fifo_count_ff, fifo_count_in;
   logic                            drop_ff, drop_in;
   logic [sfhw_pkg::HIST_AW-1:0]    hist_pos_ff, hist_pos_in;
   logic [sfhw_pkg::HIST_AW-1:0]    emit_idx_ff, emit_idx_in;
   logic [sfhw_pkg::LEN_W-1:0]      emit_cnt_ff, emit_cnt_in;
   logic                            wr_pend_ff, wr_pend_in;
   logic [sfhw_pkg::HIST_AW-1:0]    wr_pos_ff, wr_pos_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sfhw_pkg::WORD_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic                            fifo_we, fifo_re, hist_re;

   logic [sfhw_pkg::WORD_W-1:0]     fifo_mem [sfhw_pkg::FIFO_DEPTH];
   logic [sfhw_pkg::WORD_W-1:0]     fifo_rd_ff;
   logic [sfhw_pkg::WORD_W-1:0]     hist_mem [sfhw_pkg::HIST_DEPTH];
   logic [sfhw_pkg::WORD_W-1:0]     hist_rd_ff;
   logic                            hist_rd_vld_ff;
   logic [sfhw_pkg::HIST_DEPTH-1:0] hist_vld_ff;

   function automatic logic [sfhw_pkg::FIFO_AW-1:0] next_fifo(
      input logic [sfhw_pkg::FIFO_AW-1:0] idx
   );
      logic [sfhw_pkg::FIFO_AW-1:0] nxt;
      nxt = sfhw_pkg::FIFO_AW'(idx + 1'b1);
      return (idx == sfhw_pkg::FIFO_AW'(sfhw_pkg::FIFO_DEPTH - 1)) ? '0 : nxt;
   endfunction

   function automatic logic [sfhw_pkg::HIST_AW-1:0] next_pos(
      input logic [sfhw_pkg::HIST_AW-1:0] pos,
      input logic [sfhw_pkg::LEN_W-1:0]   len
   );
      logic [sfhw_pkg::LEN_W-1:0] nxt;
      nxt = sfhw_pkg::LEN_W'(pos) + 1'b1;
      return (nxt >= len) ? '0 : nxt[sfhw_pkg::HIST_AW-1:0];
   endfunction

   // A length of zero acts as one, and anything above the store depth is clamped.
   always_comb begin
      if (hist_len_ff == '0) begin
         eff_len = sfhw_pkg::LEN_W'(1);
      end else if (hist_len_ff > sfhw_pkg::LEN_W'(sfhw_pkg::HIST_DEPTH)) begin
         eff_len = sfhw_pkg::LEN_W'(sfhw_pkg::HIST_DEPTH);
      end else begin
         eff_len = hist_len_ff;
      end
   end

   assign hist_len_in = csr_write_enable ? csr_write_data : hist_len_ff;

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      fifo_head_in  = fifo_head_ff;
      fifo_tail_in  = fifo_tail_ff;
      fifo_count_in = fifo_count_ff;
      drop_in       = drop_ff;
      hist_pos_in   = hist_pos_ff;
      emit_idx_in   = emit_idx_ff;
      emit_cnt_in   = emit_cnt_ff;
      wr_pend_in    = 1'b0;
      wr_pos_in     = wr_pos_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      item_pop      = 1'b0;
      fifo_we       = 1'b0;
      fifo_re       = 1'b0;
      hist_re       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (item.is_snap) begin
                  len_in = eff_len;
                  if (sfhw_pkg::LEN_W'(hist_pos_ff) >= eff_len) begin
                     hist_pos_in = '0;
                  end
                  state_in = ST_DRAIN;
               end else begin
                  if (!drop_ff) begin
                     if (fifo_count_ff == sfhw_pkg::FIFO_CW'(sfhw_pkg::FIFO_DEPTH)) begin
                        drop_in = 1'b1;
                     end else begin
                        fifo_we       = 1'b1;
                        fifo_tail_in  = next_fifo(fifo_tail_ff);
                        fifo_count_in = fifo_count_ff + 1'b1;
                     end
                  end
                  if (item.batch_end) begin
                     drop_in = 1'b0;
                  end
               end
            end
         end
         ST_DRAIN: begin
            // Each FIFO read is written into the history store in the cycle after the read.
            if (fifo_count_ff != '0) begin
               fifo_re       = 1'b1;
               fifo_head_in  = next_fifo(fifo_head_ff);
               fifo_count_in = fifo_count_ff - 1'b1;
               wr_pend_in    = 1'b1;
               wr_pos_in     = hist_pos_ff;
               hist_pos_in   = next_pos(hist_pos_ff, len_ff);
            end else if (!wr_pend_ff) begin
               emit_idx_in = hist_pos_ff;
               emit_cnt_in = '0;
               state_in    = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            hist_re  = 1'b1;
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            // Slots never written since reset read as zero.
            rsp_valid_in = 1'b1;
            rsp_data_in  = hist_rd_vld_ff ? hist_rd_ff : '0;
            rsp_last_in  = (emit_cnt_ff == len_ff - 1'b1);
            state_in     = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = next_pos(emit_idx_ff, len_ff);
                  emit_cnt_in = emit_cnt_ff + 1'b1;
                  state_in    = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hist_len_ff   <= sfhw_pkg::HIST_LEN_RESET;
         fifo_head_ff  <= '0;
         fifo_tail_ff  <= '0;
         fifo_count_ff <= '0;
         drop_ff       <= 1'b0;
         hist_pos_ff   <= '0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hist_len_ff   <= hist_len_in;
         fifo_head_ff  <= fifo_head_in;
         fifo_tail_ff  <= fifo_tail_in;
         fifo_count_ff <= fifo_count_in;
         drop_ff       <= drop_in;
         hist_pos_ff   <= hist_pos_in;
         wr_pend_ff    <= wr_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      emit_idx_ff <= emit_idx_in;
      emit_cnt_ff <= emit_cnt_in;
      wr_pos_ff   <= wr_pos_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[fifo_tail_ff] <= item.word;
      end
      if (fifo_re) begin
         fifo_rd_ff <= fifo_mem[fifo_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         hist_mem[wr_pos_ff] <= fifo_rd_ff;
      end
      if (hist_re) begin
         hist_rd_ff     <= hist_mem[emit_idx_ff];
         hist_rd_vld_ff <= hist_vld_ff[emit_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
      end else if (wr_pend_ff) begin
         hist_vld_ff[wr_pos_ff] <= 1'b1;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_history_sample = rsp_data_ff;
   assign rsp_last_sample    = rsp_last_ff;

   always_comb begin
      status.busy       = (state_ff != ST_IDLE);
      status.emitting   = (state_ff == ST_EMIT_RD) || (state_ff == ST_EMIT_LD) ||
                          (state_ff == ST_EMIT_HOLD);
      status.fifo_count = fifo_count_ff;
   end

endmodule

/* rtl/sample_fifo_history_window.sv */
// Pushes: one request per cycle sustained while no snapshot is in progress; a push gives no result.
// Snapshot: a setup step, then each queued sample is moved from the FIFO into the history
// store, then each sample of the window is emitted, each held while the output stalls.
// The drain rate is set by the single read port of the 1024-entry sample FIFO.
// Reset is synchronous: pointers, drop flag and history valid bits clear at once,
// so the history reads as zeros; the length register returns to 64.
`include "sample_fifo_history_window_defines.svh"

module sample_fifo_history_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [sfhw_pkg::WORD_W-1:0]       req_sample_word,
   input  logic                              req_batch_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sfhw_pkg::WORD_W-1:0]       rsp_history_sample,
   output logic                              rsp_last_sample,
   input  logic                              csr_write_enable,
   input  logic [sfhw_pkg::LEN_W-1:0]        csr_write_data
);

   logic                      item_valid;
   logic                      item_pop;
   sfhw_pkg::sfhw_item_type   item;
   sfhw_pkg::sfhw_status_type status;

   sfhw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_sample_word (req_sample_word),
      .req_batch_end   (req_batch_end),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop)
   );

   sfhw_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_history_sample (rsp_history_sample),
      .rsp_last_sample    (rsp_last_sample),
      .status             (status)
   );

   `SFHW_CHECK(a_fifo_count_bound, status.fifo_count <= sfhw_pkg::FIFO_CW'(sfhw_pkg::FIFO_DEPTH), "sample FIFO count exceeds its depth")
   `SFHW_CHECK(a_rsp_only_when_busy, rsp_valid |-> status.emitting, "result offered outside a snapshot")
   `SFHW_CHECK(a_drained_before_emit, status.emitting |-> (status.fifo_count == '0), "history emitted before the FIFO drained")
   `SFHW_CHECK(a_idle_after_last, (rsp_valid && rsp_last_sample && !rsp_stall) |=> !status.busy, "back end still busy after the last transfer")

endmodule

/* bench/sample_fifo_history_window_checker.sv */
`timescale 1ns / 100ps

module sample_fifo_history_window_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [sfhw_pkg::WORD_W-1:0]         req_sample_word,
   input  logic                                req_batch_end,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [sfhw_pkg::WORD_W-1:0]         rsp_history_sample,
   input  logic                                rsp_last_sample,
   input  logic                                csr_write_enable,
   input  logic [sfhw_pkg::LEN_W-1:0]          csr_write_data,
   output int                                  error_count,
   output int                                  beats_pending
);

   typedef struct packed {
      logic [sfhw_pkg::WORD_W-1:0] word;
      logic                        is_last;
   } history_beat_type;

   logic [sfhw_pkg::WORD_W-1:0] queued_samples[$];
   logic                        dropping_batch;
   logic [sfhw_pkg::WORD_W-1:0] history_ram [sfhw_pkg::HIST_DEPTH];
   int unsigned                 write_pos;
   logic [sfhw_pkg::LEN_W-1:0]  length_reg;
   history_beat_type            expected_beats[$];
   int                          errors = 0;

   function automatic int unsigned window_length();
      if (length_reg == 0)
         return 1;
      if (length_reg > sfhw_pkg::HIST_DEPTH)
         return sfhw_pkg::HIST_DEPTH;
      return 32'(length_reg);
   endfunction

   function automatic void accept_push(input logic [sfhw_pkg::WORD_W-1:0] word,
                                       input logic batch_end);
      if (!dropping_batch) begin
         if (queued_samples.size() >= sfhw_pkg::FIFO_DEPTH)
            dropping_batch = 1'b1;
         else
            queued_samples.push_back(word);
      end
      if (batch_end)
         dropping_batch = 1'b0;
   endfunction

   // Drains every queued sample into the history window, then lists the
   // window oldest first.
   function automatic void predict_snapshot();
      int unsigned      len;
      int unsigned      idx;
      int unsigned      i;
      history_beat_type beat;
      len = window_length();
      if (write_pos >= len)
         write_pos = 0;
      while (queued_samples.size() > 0) begin
         history_ram[sfhw_pkg::HIST_AW'(write_pos)] = queued_samples.pop_front();
         write_pos++;
         if (write_pos >= len)
            write_pos = 0;
      end
      idx = write_pos;
      for (i = 0; i < len; i++) begin
         beat.word    = history_ram[sfhw_pkg::HIST_AW'(idx)];
         beat.is_last = (i + 1 == len);
         expected_beats.push_back(beat);
         idx++;
         if (idx >= len)
            idx = 0;
      end
   endfunction

   always @(posedge clock) begin : monitor
      history_beat_type want;
      if (reset) begin
         queued_samples.delete();
         expected_beats.delete();
         dropping_batch = 1'b0;
         write_pos      = 0;
         length_reg     = sfhw_pkg::HIST_LEN_RESET;
         foreach (history_ram[i])
            history_ram[i] = '0;
      end else begin
         // Results are checked before new requests so that a result can never
         // match a snapshot taken in the same cycle.
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               errors++;
               $display("%0t: unexpected result transfer, expected none, actual %08h last %0b",
                        $time, rsp_history_sample, rsp_last_sample);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_history_sample !== want.word) begin
                  errors++;
                  $display("%0t: history_sample expected %08h actual %08h",
                           $time, want.word, rsp_history_sample);
               end
               if (rsp_last_sample !== want.is_last) begin
                  errors++;
                  $display("%0t: last_sample expected %0b actual %0b",
                           $time, want.is_last, rsp_last_sample);
               end
            end
         end
         if (csr_write_enable)
            length_reg = csr_write_data;
         if (req_valid && !req_stall) begin
            if (req_cmd == sfhw_pkg::CMD_SNAPSHOT)
               predict_snapshot();
            else
               accept_push(req_sample_word, req_batch_end);
         end
      end
      error_count   <= errors;
      beats_pending <= expected_beats.size();
   end

endmodule

/* bench/sample_fifo_history_window_test.sv */
`timescale 1ns / 100ps

module sample_fifo_history_window_test;

   localparam int LIMIT_CYCLES    = 2000000;
   localparam int SETTLE_CYCLES   = 16;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int ROUND_ITEMS     = 30;
   localparam int ROUNDS          = 4;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_cmd;
   logic [sfhw_pkg::WORD_W-1:0] req_sample_word;
   logic                        req_batch_end;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [sfhw_pkg::WORD_W-1:0] rsp_history_sample;
   logic                        rsp_last_sample;
   logic                        csr_write_enable;
   logic [sfhw_pkg::LEN_W-1:0]  csr_write_data;

   int error_count;
   int beats_pending;
   int cycle_count     = 0;
   int send_burst      = 0;
   bit hold_off_armed  = 1'b0;
   bit hold_off_done   = 1'b0;

   always #1 clock = ~clock;

   sample_fifo_history_window dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_sample_word    (req_sample_word),
      .req_batch_end      (req_batch_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_history_sample (rsp_history_sample),
      .rsp_last_sample    (rsp_last_sample),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   sample_fifo_history_window_checker history_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_sample_word    (req_sample_word),
      .req_batch_end      (req_batch_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_history_sample (rsp_history_sample),
      .rsp_last_sample    (rsp_last_sample),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .error_count        (error_count),
      .beats_pending      (beats_pending)
   );

   // Mostly random gaps, with an occasional run of back-to-back transfers.
   function automatic int draw_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(8, 24);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   task automatic send_item(input logic cmd, input logic [sfhw_pkg::WORD_W-1:0] word,
                            input logic batch_end);
      int gap;
      gap = draw_gap(send_burst);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_cmd         <= cmd;
      req_sample_word <= word;
      req_batch_end   <= batch_end;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Returns once every predicted result has arrived and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [sfhw_pkg::LEN_W-1:0] value);
      wait_idle();
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** sample_fifo_history_window: FAILED **");
      $finish;
   end

   initial begin : receiver
      int gap;
      int burst;
      burst = 0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_armed && !hold_off_done) begin
            gap           = HOLD_OFF_CYCLES;
            hold_off_done = 1'b1;
         end else begin
            gap = draw_gap(burst);
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      logic [sfhw_pkg::LEN_W-1:0] len;
      int                         n;
      int                         k;
      int                         sent;
      int                         pick;
      int                         round;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_cmd          <= sfhw_pkg::CMD_PUSH;
      req_sample_word  <= '0;
      req_batch_end    <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The history reads as zeros straight after reset.
      send_item(sfhw_pkg::CMD_SNAPSHOT, '0, 1'b0);
      send_item(sfhw_pkg::CMD_PUSH, 32'h0000_0000, 1'b0);
      send_item(sfhw_pkg::CMD_PUSH, 32'hFFFF_FFFF, 1'b0);
      send_item(sfhw_pkg::CMD_PUSH, 32'hAAAA_AAAA, 1'b0);
      send_item(sfhw_pkg::CMD_PUSH, 32'h5555_5555, 1'b1);
      // The word and batch end of a snapshot are ignored.
      send_item(sfhw_pkg::CMD_SNAPSHOT, 32'hFFFF_FFFF, 1'b1);
      send_item(sfhw_pkg::CMD_PUSH, 32'h0000_0001, 1'b1);
      send_item(sfhw_pkg::CMD_PUSH, 32'h8000_0000, 1'b0);

      // Lowering the length below the write position restarts it at zero.
      write_length(7'd4);
      send_item(sfhw_pkg::CMD_SNAPSHOT, '0, 1'b0);
      write_length(7'd1);
      send_item(sfhw_pkg::CMD_PUSH, 32'h1234_5678, 1'b0);
      send_item(sfhw_pkg::CMD_SNAPSHOT, '0, 1'b0);
      // Zero acts as one, anything above the depth acts as the depth.
      write_length(7'd0);
      send_item(sfhw_pkg::CMD_PUSH, 32'hDEAD_BEEF, 1'b1);
      send_item(sfhw_pkg::CMD_SNAPSHOT, '0, 1'b0);
      write_length(7'd127);
      send_item(sfhw_pkg::CMD_SNAPSHOT, '0, 1'b0);

      // The receiver holds off while pushes keep coming behind a snapshot.
      write_length(7'd64);
      hold_off_armed = 1'b1;
      send_item(sfhw_pkg::CMD_SNAPSHOT, '0, 1'b0);
      for (k = 0; k < 20; k++)
         send_item(sfhw_pkg::CMD_PUSH, $urandom, 1'b0);

      for (round = 0; round < ROUNDS; round++) begin
         case ($urandom_range(0, 5))
            0:       len = 7'($urandom_range(65, 127));
            1:       len = 7'd0;
            default: len = 7'($urandom_range(1, 64));
         endcase
         write_length(len);
         sent = 0;
         while (sent < ROUND_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               n = $urandom_range(1, 6);
               for (k = 0; k < n; k++)
                  send_item(sfhw_pkg::CMD_PUSH, $urandom, k == n - 1);
               sent += n;
            end else if (pick < 9) begin
               send_item(sfhw_pkg::CMD_SNAPSHOT, $urandom, 1'($urandom_range(0, 1)));
               sent++;
            end else begin
               send_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
               sent++;
            end
         end
         send_item(sfhw_pkg::CMD_SNAPSHOT, $urandom, 1'b0);
      end

      wait_idle();
      if (error_count == 0)
         $display("** sample_fifo_history_window: PASSED **");
      else
         $display("** sample_fifo_history_window: FAILED **");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/sfhw_pkg.sv
rtl/sfhw_front.sv
rtl/sfhw_back.sv
rtl/sample_fifo_history_window.sv
bench/sample_fifo_history_window_checker.sv
bench/sample_fifo_history_window_test.sv
